[src/edcd_pkg.sv]
package edcd_pkg;

    localparam int TICK_W   = 22;
    localparam int DAY_W    = 17;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 7;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 2;

    localparam logic [TICK_W-1:0] TICKS_RESET = 22'd2685249;
    localparam logic [DAY_W-1:0]  DAY_MAX     = 17'd99999;

    // Place weights
    localparam logic [DAY_W-1:0] W_TEN_THOUSANDS = 17'd10000;
    localparam logic [DAY_W-1:0] W_THOUSANDS     = 17'd1000;
    localparam logic [DAY_W-1:0] W_HUNDREDS      = 17'd100;
    localparam logic [DAY_W-1:0] W_TENS          = 17'd10;

    // Input item kinds carried on s_tuser
    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } mode_t;

    // Status flags that travel with each day value
    typedef struct packed {
        logic saturated;
        logic new_day;
    } day_flags_t;

    // Common-cathode pattern, bit order gcdebfa
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] pat;
        unique case (d)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h24;
            4'd2:    pat = 7'h5D;
            4'd3:    pat = 7'h75;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h73;
            4'd6:    pat = 7'h7B;
            4'd7:    pat = 7'h25;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h77;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Decimal digit of value at weight: nine parallel compares against
    // constant multiples, result capped at 9
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [DAY_W-1:0] value,
                                                   input logic [DAY_W-1:0] weight);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (32'(value) >= 32'(k) * 32'(weight)) begin
                d = DIGIT_W'(k);
            end
        end
        return d;
    endfunction

endpackage

[src/edcd_decode.sv]
module edcd_decode (
    input  logic                           aclk,
    input  logic                           aresetn,
    // day value from the counter stage
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [edcd_pkg::DAY_W-1:0]     in_day,
    input  edcd_pkg::day_flags_t           in_flags,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // day_total, seg_ten_thousands, seg_thousands, seg_hundreds,
    // seg_tens, seg_units, zero fill
    output logic [edcd_pkg::M_DATA_W-1:0]  m_tdata,
    // new_day, day_saturated
    output logic [edcd_pkg::M_USER_W-1:0]  m_tuser
);
    import edcd_pkg::*;

    // Split stage: upper two digits and remainder below 1000
    logic                 sp_valid_reg;
    logic [DAY_W-1:0]     sp_day_reg;
    day_flags_t           sp_flags_reg;
    logic [DIGIT_W-1:0]   sp_d4_reg;
    logic [DIGIT_W-1:0]   sp_d3_reg;
    logic [9:0]           sp_rem_reg;

    logic [DIGIT_W-1:0]   d4_next;
    logic [DIGIT_W-1:0]   d3_next;
    logic [DAY_W-1:0]     rem4;
    logic [DAY_W-1:0]     rem3;
    logic                 sp_ready;

    // Output register
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [M_USER_W-1:0]  out_user_reg;
    logic [M_DATA_W-1:0]  out_data_next;
    logic                 out_ready;

    logic [DIGIT_W-1:0]   d2;
    logic [DIGIT_W-1:0]   d1;
    logic [DIGIT_W-1:0]   d0;
    logic [DAY_W-1:0]     rem_low;
    logic [DAY_W-1:0]     rem2;
    logic [DAY_W-1:0]     rem1;
    logic                 lead4;
    logic                 lead3;
    logic                 lead2;
    logic                 lead1;
    logic                 lead0;

    assign out_ready = !out_valid_reg || m_tready;
    assign sp_ready  = !sp_valid_reg || out_ready;
    assign in_ready  = sp_ready;

    // Ten-thousands and thousands places
    always_comb begin
        d4_next = digit_of(in_day, W_TEN_THOUSANDS);
        rem4    = in_day - DAY_W'(DAY_W'(d4_next) * W_TEN_THOUSANDS);
        d3_next = digit_of(rem4, W_THOUSANDS);
        rem3    = rem4 - DAY_W'(DAY_W'(d3_next) * W_THOUSANDS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_valid_reg <= 1'b0;
        end else if (sp_ready) begin
            sp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sp_ready && in_valid) begin
            sp_day_reg   <= in_day;
            sp_flags_reg <= in_flags;
            sp_d4_reg    <= d4_next;
            sp_d3_reg    <= d3_next;
            sp_rem_reg   <= rem3[9:0];
        end
    end

    // Lower three places, leading-zero blanking and segment lookup
    always_comb begin
        rem_low = DAY_W'(sp_rem_reg);
        d2      = digit_of(rem_low, W_HUNDREDS);
        rem2    = rem_low - DAY_W'(DAY_W'(d2) * W_HUNDREDS);
        d1      = digit_of(rem2, W_TENS);
        rem1    = rem2 - DAY_W'(DAY_W'(d1) * W_TENS);
        d0      = rem1[DIGIT_W-1:0];

        lead4 = (sp_d4_reg == '0);
        lead3 = lead4 && (sp_d3_reg == '0);
        lead2 = lead3 && (d2 == '0);
        lead1 = lead2 && (d1 == '0);
        lead0 = lead1 && (d0 == '0);

        out_data_next        = '0;
        out_data_next[16:0]  = sp_day_reg;
        out_data_next[23:17] = lead4 ? '0 : seg_of(sp_d4_reg);
        out_data_next[30:24] = lead3 ? '0 : seg_of(sp_d3_reg);
        out_data_next[37:31] = lead2 ? '0 : seg_of(d2);
        out_data_next[44:38] = lead1 ? '0 : seg_of(d1);
        out_data_next[51:45] = lead0 ? '0 : seg_of(d0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= sp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && sp_valid_reg) begin
            out_data_reg <= out_data_next;
            out_user_reg <= {sp_flags_reg.saturated, sp_flags_reg.new_day};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[src/elapsed_day_counter_display.sv]
// An accepted transaction passes the counter stage, digit-split stage and
// output register in turn to m_tdata. Throughput: one transaction per cycle
// with m_tready high; each stage holds one item, stalling independently.
// Reset (aresetn low, synchronous) clears tick and day counts, empties the
// pipeline and loads ticks_per_day with 2685249.
module elapsed_day_counter_display (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: ticks_per_day
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edcd_pkg::TICK_W-1:0]     cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_value, zero fill
    input  logic [edcd_pkg::S_DATA_W-1:0]   s_tdata,
    // mode
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // day_total, seg_ten_thousands, seg_thousands, seg_hundreds,
    // seg_tens, seg_units, zero fill
    output logic [edcd_pkg::M_DATA_W-1:0]   m_tdata,
    // new_day, day_saturated
    output logic [edcd_pkg::M_USER_W-1:0]   m_tuser
);
    import edcd_pkg::*;

    logic [TICK_W-1:0]  period_reg;
    logic [TICK_W-1:0]  tick_count_reg;
    logic [TICK_W-1:0]  tick_count_next;
    logic [DAY_W-1:0]   day_count_reg;
    logic [DAY_W-1:0]   day_count_next;
    logic               new_day_next;
    logic [TICK_W:0]    tick_inc;
    logic [DAY_W-1:0]   load_value;
    logic               accept;

    // Counter stage register toward the decoder
    logic               cs_valid_reg;
    logic [DAY_W-1:0]   cs_day_reg;
    day_flags_t         cs_flags_reg;
    logic               cs_ready;
    logic               dec_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= TICKS_RESET;
        end else if (cfg_valid) begin
            period_reg <= cfg_data;
        end
    end

    assign cs_ready   = !cs_valid_reg || dec_ready;
    assign s_tready   = cs_ready;
    assign accept     = s_tvalid && cs_ready;
    assign load_value = s_tdata[DAY_W-1:0];

    // Tick and day count update
    always_comb begin
        tick_inc        = {1'b0, tick_count_reg} + 1'b1;
        tick_count_next = tick_count_reg;
        day_count_next  = day_count_reg;
        new_day_next    = 1'b0;
        unique case (mode_t'(s_tuser))
            MODE_LOAD: begin
                day_count_next = (load_value > DAY_MAX) ? DAY_MAX : load_value;
            end
            MODE_TICK: begin
                if (tick_inc >= {1'b0, period_reg}) begin
                    tick_count_next = '0;
                    if (day_count_reg < DAY_MAX) begin
                        day_count_next = day_count_reg + 1'b1;
                        new_day_next   = 1'b1;
                    end else begin
                        day_count_next = DAY_MAX;
                    end
                end else begin
                    tick_count_next = tick_inc[TICK_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            day_count_reg  <= '0;
            cs_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                tick_count_reg <= tick_count_next;
                day_count_reg  <= day_count_next;
            end
            if (cs_ready) begin
                cs_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cs_day_reg             <= day_count_next;
            cs_flags_reg.new_day   <= new_day_next;
            cs_flags_reg.saturated <= (day_count_next >= DAY_MAX);
        end
    end

    edcd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cs_valid_reg),
        .in_ready (dec_ready),
        .in_day   (cs_day_reg),
        .in_flags (cs_flags_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
